### design/adp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package adp_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_PROFILE = 2'd0;
	localparam logic [1:0] KIND_FLAGS   = 2'd1;
	localparam logic [1:0] KIND_LABEL   = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	// Smallest buffer that can hold a descriptor header.
	localparam logic [15:0] MIN_BUFFER = 16'd5;
	// Bytes in one application profile entry.
	localparam int unsigned PROFILE_BYTES = 5;
	// Fixed bytes besides the profiles in the descriptor length (profiles length, flags, priority).
	localparam logic [9:0] FIXED_BYTES = 10'd3;

	localparam logic [7:0] FLAG_BOUND_MASK = 8'h80;
	localparam logic [7:0] FLAG_VIS_MASK   = 8'h60;
	localparam logic [7:0] FLAG_RES_MASK   = 8'h1f;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tag;
		logic [15:0] profile;
		logic [7:0]  ver_major;
		logic [7:0]  ver_minor;
		logic [7:0]  ver_micro;
		logic        service_bound;
		logic [1:0]  visibility;
		logic [4:0]  reserved_bits;
		logic [7:0]  priority_res;
		logic [7:0]  label;
		logic        last;
	} res_t;

endpackage

`default_nettype wire

### design/application_descriptor_parser_top.sv
// A result is registered into the output register, or into the skid register while the output is stalled.
// One byte is accepted per cycle while the input is not stalled. Each byte is decoded by a single registered pass.
// Input stall rises only when both the output register and the skid register hold results.
// Reset (arst_n low, asynchronous) returns the parser to idle, waiting for a first byte,
// and empties the output and skid registers.
`timescale 1ns / 1ps
`default_nettype none

module application_descriptor_parser_top
	import adp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        data_valid,
	output logic             data_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_byte,
	input  wire logic [15:0] buffer_length,

	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [1:0]       kind,
	output logic [7:0]       tag,
	output logic [15:0]      profile,
	output logic [7:0]       ver_major,
	output logic [7:0]       ver_minor,
	output logic [7:0]       ver_micro,
	output logic             service_bound,
	output logic [1:0]       visibility,
	output logic [4:0]       reserved_bits,
	output logic [7:0]       priority_res,
	output logic [7:0]       label,
	output logic             last
);

	// Parser phases. Each phase names what the next non-first byte holds.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEN,
		PH_PLEN,
		PH_PROF,
		PH_FLAGS,
		PH_PRIO,
		PH_LABELS
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] avail_q, avail_d;
	logic [7:0]  tag_q, tag_d;
	logic [7:0]  desc_len_q, desc_len_d;
	logic [7:0]  prof_len_q, prof_len_d;
	logic [5:0]  prof_left_q, prof_left_d;
	logic [2:0]  prof_idx_q, prof_idx_d;
	logic [31:0] prof_hold_q, prof_hold_d;
	logic [7:0]  flags_q, flags_d;
	logic [7:0]  labels_left_q, labels_left_d;

	// Output register plus one skid register. The skid register catches a result
	// produced while the output is stalled, so the input never waits on a single
	// pending result.
	res_t out_q, skid_q, res_d;
	logic out_valid_q, skid_valid_q;
	logic res_new;

	logic accept;
	logic out_take;

	// Division of the profiles length by five, done as a multiply by the
	// reciprocal. The product is exact for every 8-bit dividend.
	logic [17:0] div5_prod;
	logic [5:0]  prof_count;

	// Label count as a signed difference; zero or negative means no labels.
	logic signed [10:0] label_diff;
	logic [7:0]         label_count;

	assign data_stall = skid_valid_q;
	assign accept     = data_valid && !data_stall;
	assign out_take   = out_valid_q && !res_stall;

	assign div5_prod  = {10'd0, data_byte} * 18'd205;
	assign prof_count = div5_prod[15:10];

	assign label_diff  = $signed({3'd0, desc_len_q}) - $signed({3'd0, prof_len_q})
		- $signed({1'b0, FIXED_BYTES});
	assign label_count = (label_diff > 11'sd0) ? label_diff[7:0] : 8'd0;

	always_comb begin
		phase_d       = phase_q;
		avail_d       = avail_q;
		tag_d         = tag_q;
		desc_len_d    = desc_len_q;
		prof_len_d    = prof_len_q;
		prof_left_d   = prof_left_q;
		prof_idx_d    = prof_idx_q;
		prof_hold_d   = prof_hold_q;
		flags_d       = flags_q;
		labels_left_d = labels_left_q;
		res_new       = 1'b0;
		res_d         = '0;
		res_d.tag     = tag_q;

		if (accept) begin
			if (first_byte) begin
				// A first byte always restarts, even inside a descriptor.
				tag_d     = data_byte;
				avail_d   = buffer_length;
				res_d.tag = data_byte;
				if (buffer_length < MIN_BUFFER) begin
					phase_d    = PH_IDLE;
					res_new    = 1'b1;
					res_d.kind = KIND_ERROR;
					res_d.last = 1'b1;
				end else begin
					phase_d = PH_LEN;
				end
			end else begin
				unique case (phase_q)
					PH_LEN: begin
						desc_len_d = data_byte;
						if (avail_q < ({8'd0, data_byte} + 16'd2)) begin
							phase_d    = PH_IDLE;
							res_new    = 1'b1;
							res_d.kind = KIND_ERROR;
							res_d.last = 1'b1;
						end else begin
							phase_d = PH_PLEN;
						end
					end
					PH_PLEN: begin
						prof_len_d  = data_byte;
						prof_left_d = prof_count;
						prof_idx_d  = 3'd0;
						prof_hold_d = '0;
						phase_d     = (prof_count != 6'd0) ? PH_PROF : PH_FLAGS;
					end
					PH_PROF: begin
						if (prof_idx_q < 3'(PROFILE_BYTES - 1)) begin
							prof_hold_d = {prof_hold_q[23:0], data_byte};
							prof_idx_d  = prof_idx_q + 3'd1;
						end else begin
							res_new         = 1'b1;
							res_d.kind      = KIND_PROFILE;
							res_d.profile   = prof_hold_q[31:16];
							res_d.ver_major = prof_hold_q[15:8];
							res_d.ver_minor = prof_hold_q[7:0];
							res_d.ver_micro = data_byte;
							prof_idx_d      = 3'd0;
							prof_hold_d     = '0;
							prof_left_d     = prof_left_q - 6'd1;
							if (prof_left_q == 6'd1) begin
								phase_d = PH_FLAGS;
							end
						end
					end
					PH_FLAGS: begin
						flags_d = data_byte;
						phase_d = PH_PRIO;
					end
					PH_PRIO: begin
						labels_left_d       = label_count;
						res_new             = 1'b1;
						res_d.kind          = KIND_FLAGS;
						res_d.last          = (label_count == 8'd0);
						res_d.service_bound = |(flags_q & FLAG_BOUND_MASK);
						res_d.visibility    = flags_q[6:5] & FLAG_VIS_MASK[6:5];
						res_d.reserved_bits = flags_q[4:0] & FLAG_RES_MASK[4:0];
						res_d.priority_res  = data_byte;
						phase_d = (label_count != 8'd0) ? PH_LABELS : PH_IDLE;
					end
					PH_LABELS: begin
						labels_left_d = labels_left_q - 8'd1;
						res_new       = 1'b1;
						res_d.kind    = KIND_LABEL;
						res_d.last    = (labels_left_q == 8'd1);
						res_d.label   = data_byte;
						if (labels_left_q == 8'd1) begin
							phase_d = PH_IDLE;
						end
					end
					default: begin
						// Stray bytes while idle are dropped.
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			avail_q       <= '0;
			tag_q         <= '0;
			desc_len_q    <= '0;
			prof_len_q    <= '0;
			prof_left_q   <= '0;
			prof_idx_q    <= '0;
			prof_hold_q   <= '0;
			flags_q       <= '0;
			labels_left_q <= '0;
		end else begin
			phase_q       <= phase_d;
			avail_q       <= avail_d;
			tag_q         <= tag_d;
			desc_len_q    <= desc_len_d;
			prof_len_q    <= prof_len_d;
			prof_left_q   <= prof_left_d;
			prof_idx_q    <= prof_idx_d;
			prof_hold_q   <= prof_hold_d;
			flags_q       <= flags_d;
			labels_left_q <= labels_left_d;
		end
	end

	// Output and skid control. While the skid register is full the input is
	// stalled, so no new result can arrive in that cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_take || !out_valid_q) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= res_new;
				end
			end else if (res_new) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (res_new) begin
				out_q <= res_d;
			end
		end else if (res_new) begin
			skid_q <= res_d;
		end
	end

	assign res_valid     = out_valid_q;
	assign kind          = out_q.kind;
	assign tag           = out_q.tag;
	assign profile       = out_q.profile;
	assign ver_major     = out_q.ver_major;
	assign ver_minor     = out_q.ver_minor;
	assign ver_micro     = out_q.ver_micro;
	assign service_bound = out_q.service_bound;
	assign visibility    = out_q.visibility;
	assign reserved_bits = out_q.reserved_bits;
	assign priority_res  = out_q.priority_res;
	assign label         = out_q.label;
	assign last          = out_q.last;

endmodule

`default_nettype wire

### design/adp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module adp_checker
	import adp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        data_stall,
	input wire logic        res_valid,
	input wire logic        res_stall,
	input wire logic [1:0]  kind,
	input wire logic [15:0] profile,
	input wire logic [7:0]  label,
	input wire logic        last
);

	// The input is only held off while a result is pending at the output.
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> res_valid)
		else $error("input stalled with no result pending");

	// A stalled result holds.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(kind) && $stable(last))
		else $error("stalled result changed");

	// A length error always ends the descriptor.
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_ERROR |-> last)
		else $error("length error without last mark");

	// Fields foreign to the kind read as zero.
	a_profile_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != KIND_PROFILE |-> profile == 16'd0)
		else $error("profile set on a non-profile result");

	a_label_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != KIND_LABEL |-> label == 8'd0)
		else $error("label set on a non-label result");

endmodule

bind application_descriptor_parser_top adp_checker u_adp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.data_stall (data_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.kind       (kind),
	.profile    (profile),
	.label      (label),
	.last       (last)
);

`default_nettype wire
